### rtl/assert_macros.svh
// Assertion helpers shared by the RTL; they compile away for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### rtl/hrd_pkg.sv
`timescale 1ns / 1ps

package hrd_pkg;

    // Field widths
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned COLOR_W = 24;
    localparam int unsigned HUE_W   = 10;
    localparam int unsigned OPND_W  = 14;   // wide multiplicand, holds 15300
    localparam int unsigned ACC_W   = 22;   // 255 * 15300 fits
    localparam int unsigned STEP_W  = 3;    // 8 steps per phase

    // HSV constants
    localparam logic [8:0]        HUE_MAX    = 9'd359;
    localparam logic [OPND_W-1:0] HUE_SPAN   = 14'd15300;
    localparam logic [7:0]        CHAN_FULL  = 8'hFF;

    // Divisors pre-shifted for an 8-bit quotient
    localparam logic [ACC_W-1:0] DVS_255  = 22'(255 << 7);
    localparam logic [ACC_W-1:0] DVS_SPAN = 22'(15300 << 7);

    // Input commands
    typedef enum logic [1:0] {
        CMD_SET_RGB = 2'd0,
        CMD_SET_HSV = 2'd1,
        CMD_REFRESH = 2'd2,
        CMD_SPARE   = 2'd3
    } t_cmd;

    // Configuration register indexes
    localparam logic [0:0] REG_BRIGHTNESS   = 1'b0;
    localparam logic [0:0] REG_COMMON_ANODE = 1'b1;

    // Multiply/divide unit modes
    typedef enum logic [1:0] {
        MD_MUL_ONLY = 2'd0,
        MD_DIV_255  = 2'd1,
        MD_DIV_SPAN = 2'd2
    } t_md_mode;

    typedef enum logic [1:0] {
        MDS_IDLE = 2'd0,
        MDS_MUL  = 2'd1,
        MDS_DIV  = 2'd2
    } t_md_state;

    typedef struct packed {
        logic     start;
        t_md_mode mode;
    } t_md_req;

    typedef struct packed {
        logic done;
        logic busy;
    } t_md_rsp;

    // Top level sequencer
    typedef enum logic [3:0] {
        S_IDLE = 4'd0,
        S_PROD = 4'd1,
        S_MIN  = 4'd2,
        S_I1   = 4'd3,
        S_I2   = 4'd4,
        S_RED  = 4'd5,
        S_GRN  = 4'd6,
        S_BLU  = 4'd7,
        S_OUT  = 4'd8
    } t_state;

endpackage

### rtl/hsv_rgb_led_dimmer_core.sv
`timescale 1ns / 1ps

// RGB LED dimmer core. Each item either loads a packed RGB colour, converts
// hue/saturation/value to RGB and stores it, or (refresh and spare codes)
// refreshes the duties from the stored colour; every item returns one result
// with the three PWM duties (scaled by brightness/255, inverted when
// common_anode is set) and the stored colour. All products and divides go
// through one bit-serial multiply/divide unit: a load, the multiply steps, the
// divide steps and the hand-back of the quotient for each scaled operation,
// with no divide steps for the bare s*t product. An HSV item runs one product
// s*t, then min, i1 and i2, then the three channel scalings; an RGB, refresh
// or spare item runs only the three channel scalings. The block is ready for
// the next item in the same cycle as a result is presented. One item is in
// work at a time; a finished result waits in the output register while the
// next item is taken, and the next result holds the input off until the
// waiting one has been taken.
`include "assert_macros.svh"

module hsv_rgb_led_dimmer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // packed_rgb[23:0], hue[33:24], saturation[41:34], value_level[49:42], zero pad
    input  logic [55:0] s_axis_tdata,
    // command[1:0]
    input  logic [1:0]  s_axis_tuser,
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red_duty[7:0], green_duty[15:8], blue_duty[23:16], current_colour[47:24]
    output logic [47:0] m_axis_tdata
);

    localparam int unsigned CW = hrd_pkg::CHAN_W;

    hrd_pkg::t_state  r_state, n_state;
    logic             r_go, n_go;
    logic             r_ovalid, n_ovalid;
    logic [CW-1:0]    r_bright;
    logic             r_ca;
    logic [hrd_pkg::COLOR_W-1:0] r_colour, n_colour;
    logic [47:0]      r_odata, n_odata;

    // per-item working registers
    hrd_pkg::t_cmd    r_cmd;
    logic [CW-1:0]    r_sat, r_val;
    logic [2:0]       r_sector;
    logic [5:0]       r_rem;
    logic [hrd_pkg::OPND_W-1:0] r_st, n_st;
    logic [CW-1:0]    r_mn, n_mn;
    logic [CW-1:0]    r_i1, n_i1;
    logic [CW-1:0]    r_red, n_red;
    logic [CW-1:0]    r_grn, n_grn;
    logic [CW-1:0]    r_blu, n_blu;

    logic             accept;
    logic             out_free;
    logic [2:0]       hue_sector;
    logic [5:0]       hue_rem;
    hrd_pkg::t_md_req md_req;
    hrd_pkg::t_md_rsp md_rsp;
    logic [CW-1:0]    md_a;
    logic [hrd_pkg::OPND_W-1:0] md_b;
    logic [CW-1:0]    md_quot;
    logic [hrd_pkg::ACC_W-1:0]  md_prod;
    logic [15:0]      i2_arg;
    logic [CW-1:0]    inv_mask;

    assign s_axis_tready = (r_state == hrd_pkg::S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;
    assign inv_mask      = {CW{r_ca}};
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    hrd_hue_split u_hue (
        .i_hue    (s_axis_tdata[33:24]),
        .o_sector (hue_sector),
        .o_rem    (hue_rem)
    );

    hrd_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .i_a     (md_a),
        .i_b     (md_b),
        .o_rsp   (md_rsp),
        .o_quot  (md_quot),
        .o_prod  (md_prod)
    );

    // 15300 - s*(60-t) = 15300 - 60*s + s*t
    assign i2_arg = 16'(hrd_pkg::HUE_SPAN) - {2'b00, r_sat, 6'b0}
                  + {6'b0, r_sat, 2'b0} + {2'b00, r_st};

    // operand select for the shared unit
    always_comb begin
        md_req.start = r_go;
        md_req.mode  = hrd_pkg::MD_DIV_255;
        md_a         = r_val;
        md_b         = '0;
        unique case (r_state)
            hrd_pkg::S_PROD: begin
                md_req.mode = hrd_pkg::MD_MUL_ONLY;
                md_a        = r_sat;
                md_b        = hrd_pkg::OPND_W'(r_rem);
            end
            hrd_pkg::S_MIN: begin
                md_b = hrd_pkg::OPND_W'(hrd_pkg::CHAN_FULL - r_sat);
            end
            hrd_pkg::S_I1: begin
                md_req.mode = hrd_pkg::MD_DIV_SPAN;
                md_b        = hrd_pkg::HUE_SPAN - r_st;
            end
            hrd_pkg::S_I2: begin
                md_req.mode = hrd_pkg::MD_DIV_SPAN;
                md_b        = i2_arg[hrd_pkg::OPND_W-1:0];
            end
            hrd_pkg::S_RED: begin
                md_a = r_colour[23:16];
                md_b = hrd_pkg::OPND_W'(r_bright);
            end
            hrd_pkg::S_GRN: begin
                md_a = r_colour[15:8];
                md_b = hrd_pkg::OPND_W'(r_bright);
            end
            hrd_pkg::S_BLU: begin
                md_a = r_colour[7:0];
                md_b = hrd_pkg::OPND_W'(r_bright);
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hrd_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (hrd_pkg::t_cmd'(s_axis_tuser) == hrd_pkg::CMD_SET_HSV) ?
                              hrd_pkg::S_PROD : hrd_pkg::S_RED;
                end
            end
            hrd_pkg::S_PROD: if (md_rsp.done) n_state = hrd_pkg::S_MIN;
            hrd_pkg::S_MIN:  if (md_rsp.done) n_state = hrd_pkg::S_I1;
            hrd_pkg::S_I1:   if (md_rsp.done) n_state = hrd_pkg::S_I2;
            hrd_pkg::S_I2:   if (md_rsp.done) n_state = hrd_pkg::S_RED;
            hrd_pkg::S_RED:  if (md_rsp.done) n_state = hrd_pkg::S_GRN;
            hrd_pkg::S_GRN:  if (md_rsp.done) n_state = hrd_pkg::S_BLU;
            hrd_pkg::S_BLU:  if (md_rsp.done) n_state = hrd_pkg::S_OUT;
            hrd_pkg::S_OUT:  if (out_free)    n_state = hrd_pkg::S_IDLE;
            default: n_state = hrd_pkg::S_IDLE;
        endcase
    end

    // kick the unit on entry to each compute state
    assign n_go = (n_state != r_state) && (n_state != hrd_pkg::S_IDLE)
               && (n_state != hrd_pkg::S_OUT);

    // outputs and working registers
    always_comb begin
        n_colour = r_colour;
        n_st     = r_st;
        n_mn     = r_mn;
        n_i1     = r_i1;
        n_red    = r_red;
        n_grn    = r_grn;
        n_blu    = r_blu;
        n_odata  = r_odata;
        n_ovalid = r_ovalid && !m_axis_tready;
        unique case (r_state)
            hrd_pkg::S_IDLE: begin
                if (accept &&
                    (hrd_pkg::t_cmd'(s_axis_tuser) == hrd_pkg::CMD_SET_RGB)) begin
                    n_colour = s_axis_tdata[23:0];
                end
            end
            hrd_pkg::S_PROD: if (md_rsp.done) n_st = md_prod[hrd_pkg::OPND_W-1:0];
            hrd_pkg::S_MIN:  if (md_rsp.done) n_mn = md_quot;
            hrd_pkg::S_I1:   if (md_rsp.done) n_i1 = md_quot;
            hrd_pkg::S_I2: begin
                if (md_rsp.done) begin
                    // quotient here is i2
                    case (r_sector)
                        3'd0:    n_colour = {r_val,   md_quot, r_mn};
                        3'd1:    n_colour = {r_i1,    r_val,   r_mn};
                        3'd2:    n_colour = {r_mn,    r_val,   md_quot};
                        3'd3:    n_colour = {r_mn,    r_i1,    r_val};
                        3'd4:    n_colour = {md_quot, r_mn,    r_val};
                        default: n_colour = {r_val,   r_mn,    r_i1};
                    endcase
                end
            end
            hrd_pkg::S_RED: if (md_rsp.done) n_red = md_quot ^ inv_mask;
            hrd_pkg::S_GRN: if (md_rsp.done) n_grn = md_quot ^ inv_mask;
            hrd_pkg::S_BLU: if (md_rsp.done) n_blu = md_quot ^ inv_mask;
            hrd_pkg::S_OUT: begin
                if (out_free) begin
                    n_odata  = {r_colour, r_blu, r_grn, r_red};
                    n_ovalid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control, configuration and stored colour
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hrd_pkg::S_IDLE;
            r_go     <= 1'b0;
            r_ovalid <= 1'b0;
            r_bright <= hrd_pkg::CHAN_FULL;
            r_ca     <= 1'b0;
            r_colour <= '0;
        end else begin
            r_state  <= n_state;
            r_go     <= n_go;
            r_ovalid <= n_ovalid;
            r_colour <= n_colour;
            if (i_cfg_we) begin
                if (i_cfg_addr == hrd_pkg::REG_BRIGHTNESS) begin
                    r_bright <= i_cfg_data;
                end else if (i_cfg_addr == hrd_pkg::REG_COMMON_ANODE) begin
                    r_ca <= i_cfg_data[0];
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd    <= hrd_pkg::t_cmd'(s_axis_tuser);
            r_sat    <= s_axis_tdata[41:34];
            r_val    <= s_axis_tdata[49:42];
            r_sector <= hue_sector;
            r_rem    <= hue_rem;
        end
        r_st    <= n_st;
        r_mn    <= n_mn;
        r_i1    <= n_i1;
        r_red   <= n_red;
        r_grn   <= n_grn;
        r_blu   <= n_blu;
        r_odata <= n_odata;
    end

    // checks
    `ASSERT_NXT(a_one_item, i_clk, i_rst_n, accept, !s_axis_tready,
                "second item taken while busy")
    `ASSERT_IMP(a_done_in_work, i_clk, i_rst_n, md_rsp.done,
                (r_state != hrd_pkg::S_IDLE) && (r_state != hrd_pkg::S_OUT),
                "unit result with no step waiting")
    `ASSERT_IMP(a_go_idle_unit, i_clk, i_rst_n, r_go, !md_rsp.busy,
                "unit started while busy")
    `ASSERT_IMP(a_full_scale, i_clk, i_rst_n,
                m_axis_tvalid && !r_ca && (r_bright == hrd_pkg::CHAN_FULL),
                m_axis_tdata[7:0] == m_axis_tdata[47:40],
                "full-scale red duty differs from colour")
    `ASSERT_IMP(a_hsv_cmd_path, i_clk, i_rst_n, (r_state == hrd_pkg::S_PROD),
                (r_cmd == hrd_pkg::CMD_SET_HSV), "HSV step for a non-HSV item")

endmodule

### rtl/hrd_hue_split.sv
`timescale 1ns / 1ps

// Clamp hue to 0..359 and split it into a 60-degree sector and remainder.
module hrd_hue_split (
    input  logic signed [hrd_pkg::HUE_W-1:0] i_hue,
    output logic        [2:0]                o_sector,
    output logic        [5:0]                o_rem
);

    logic [8:0] hu;
    logic [8:0] base;
    logic [8:0] diff;

    always_comb begin
        // clamp
        if (i_hue[hrd_pkg::HUE_W-1]) begin
            hu = 9'd0;
        end else if (i_hue[8:0] > hrd_pkg::HUE_MAX) begin
            hu = hrd_pkg::HUE_MAX;
        end else begin
            hu = i_hue[8:0];
        end

        // sector by threshold compare
        if (hu >= 9'd300) begin
            o_sector = 3'd5;
            base     = 9'd300;
        end else if (hu >= 9'd240) begin
            o_sector = 3'd4;
            base     = 9'd240;
        end else if (hu >= 9'd180) begin
            o_sector = 3'd3;
            base     = 9'd180;
        end else if (hu >= 9'd120) begin
            o_sector = 3'd2;
            base     = 9'd120;
        end else if (hu >= 9'd60) begin
            o_sector = 3'd1;
            base     = 9'd60;
        end else begin
            o_sector = 3'd0;
            base     = 9'd0;
        end

        diff  = hu - base;
        o_rem = diff[5:0];
    end

endmodule

### rtl/hrd_muldiv.sv
`timescale 1ns / 1ps

// Bit-serial floor(a*b/d): 8 shift-add steps, then 8 restoring-divide
// steps giving one quotient bit each. In MD_MUL_ONLY the product is the result.
module hrd_muldiv (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hrd_pkg::t_md_req                  i_req,
    input  logic [hrd_pkg::CHAN_W-1:0]        i_a,
    input  logic [hrd_pkg::OPND_W-1:0]        i_b,
    output hrd_pkg::t_md_rsp                  o_rsp,
    output logic [hrd_pkg::CHAN_W-1:0]        o_quot,
    output logic [hrd_pkg::ACC_W-1:0]         o_prod
);

    hrd_pkg::t_md_state r_state, n_state;
    hrd_pkg::t_md_mode  r_mode, n_mode;
    logic [hrd_pkg::STEP_W-1:0] r_cnt, n_cnt;
    logic                       r_done, n_done;
    logic [hrd_pkg::CHAN_W-1:0] r_mier, n_mier;
    logic [hrd_pkg::ACC_W-1:0]  r_mcand, n_mcand;
    logic [hrd_pkg::ACC_W-1:0]  r_acc, n_acc;
    logic [hrd_pkg::ACC_W-1:0]  r_dvs, n_dvs;
    logic [hrd_pkg::CHAN_W-1:0] r_quo, n_quo;
    logic                       last_step;

    assign last_step = (r_cnt == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hrd_pkg::MDS_IDLE: begin
                if (i_req.start) begin
                    n_state = hrd_pkg::MDS_MUL;
                end
            end
            hrd_pkg::MDS_MUL: begin
                if (last_step) begin
                    n_state = (r_mode == hrd_pkg::MD_MUL_ONLY) ?
                              hrd_pkg::MDS_IDLE : hrd_pkg::MDS_DIV;
                end
            end
            hrd_pkg::MDS_DIV: begin
                if (last_step) begin
                    n_state = hrd_pkg::MDS_IDLE;
                end
            end
            default: n_state = hrd_pkg::MDS_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_mode  = r_mode;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_mier  = r_mier;
        n_mcand = r_mcand;
        n_acc   = r_acc;
        n_dvs   = r_dvs;
        n_quo   = r_quo;
        unique case (r_state)
            hrd_pkg::MDS_IDLE: begin
                if (i_req.start) begin
                    n_mode  = i_req.mode;
                    n_cnt   = '1;
                    n_mier  = i_a;
                    n_mcand = hrd_pkg::ACC_W'(i_b);
                    n_acc   = '0;
                    n_dvs   = (i_req.mode == hrd_pkg::MD_DIV_SPAN) ?
                              hrd_pkg::DVS_SPAN : hrd_pkg::DVS_255;
                end
            end
            hrd_pkg::MDS_MUL: begin
                // one multiplier bit per cycle
                if (r_mier[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mier  = r_mier >> 1;
                n_mcand = r_mcand << 1;
                n_cnt   = r_cnt - 1'b1;
                if (last_step && (r_mode == hrd_pkg::MD_MUL_ONLY)) begin
                    n_done = 1'b1;
                end
            end
            hrd_pkg::MDS_DIV: begin
                // one quotient bit per cycle
                if (r_acc >= r_dvs) begin
                    n_acc = r_acc - r_dvs;
                    n_quo = {r_quo[hrd_pkg::CHAN_W-2:0], 1'b1};
                end else begin
                    n_quo = {r_quo[hrd_pkg::CHAN_W-2:0], 1'b0};
                end
                n_dvs = r_dvs >> 1;
                n_cnt = r_cnt - 1'b1;
                if (last_step) begin
                    n_done = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hrd_pkg::MDS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_cnt   <= n_cnt;
        r_mier  <= n_mier;
        r_mcand <= n_mcand;
        r_acc   <= n_acc;
        r_dvs   <= n_dvs;
        r_quo   <= n_quo;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = (r_state != hrd_pkg::MDS_IDLE);
    assign o_quot     = r_quo;
    assign o_prod     = r_acc;

endmodule

### bench/hsv_rgb_led_dimmer_core_test.sv
`timescale 1ns / 1ps

module hsv_rgb_led_dimmer_core_test;

    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN_CYCLES = 200;

    // One result item, red in the lowest byte
    typedef struct packed {
        logic [23:0] colour;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } t_duty_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_addr;
    logic [7:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // packed_rgb[23:0], hue[33:24], saturation[41:34], value_level[49:42], zero pad
    logic [55:0] s_axis_tdata;
    // command[1:0]
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // red_duty[7:0], green_duty[15:8], blue_duty[23:16], current_colour[47:24]
    logic [47:0] m_axis_tdata;

    // Shadow of the block's registers and stored colour
    logic [7:0]   brightness_q;
    logic         anode_q;
    logic [23:0]  led_colour;
    t_duty_result pending_duties[$];

    int          error_count = 0;
    int          cycle_count = 0;
    int          stall_mode = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    int          hold_req = 0;
    int          hold_left = 0;
    bit          gaps_on = 1'b0;
    int          burst_left = 0;

    hsv_rgb_led_dimmer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("hsv_rgb_led_dimmer_core_test: done, errors");
            $finish;
        end
    end

    // HSV to packed RGB, hue clamped to 0..359
    function automatic logic [23:0] hsv_colour(logic [9:0] hue, logic [7:0] sat,
                                               logic [7:0] val);
        int h, sector, t, v, s, lo, i1, i2;
        logic [7:0] r, g, b;
        h = int'($signed(hue));
        if (h < 0) h = 0;
        if (h > 359) h = 359;
        sector = h / 60;
        t = h % 60;
        v = int'(val);
        s = int'(sat);
        lo = (v * (255 - s)) / 255;
        i1 = (v * (15300 - s * t)) / 15300;
        i2 = (v * (15300 - s * (60 - t))) / 15300;
        case (sector)
            0:       begin r = v[7:0];  g = i2[7:0]; b = lo[7:0]; end
            1:       begin r = i1[7:0]; g = v[7:0];  b = lo[7:0]; end
            2:       begin r = lo[7:0]; g = v[7:0];  b = i2[7:0]; end
            3:       begin r = lo[7:0]; g = i1[7:0]; b = v[7:0];  end
            4:       begin r = i2[7:0]; g = lo[7:0]; b = v[7:0];  end
            default: begin r = v[7:0];  g = lo[7:0]; b = i1[7:0]; end
        endcase
        return {r, g, b};
    endfunction

    // Brightness scaling, then inversion for common anode
    function automatic logic [7:0] channel_duty(logic [7:0] chan);
        int d;
        d = (int'(chan) * int'(brightness_q)) / 255;
        if (anode_q) d = 255 - d;
        return d[7:0];
    endfunction

    // Update the stored colour for one accepted item and queue its result
    task automatic apply_led_command(input hrd_pkg::t_cmd cmd, input logic [23:0] rgb,
                                     input logic [9:0] hue, input logic [7:0] sat,
                                     input logic [7:0] val);
        t_duty_result res;
        case (cmd)
            hrd_pkg::CMD_SET_RGB: led_colour = rgb;
            hrd_pkg::CMD_SET_HSV: led_colour = hsv_colour(hue, sat, val);
            default:              ;  // refresh and spare code keep the colour
        endcase
        res.red    = channel_duty(led_colour[23:16]);
        res.green  = channel_duty(led_colour[15:8]);
        res.blue   = channel_duty(led_colour[7:0]);
        res.colour = led_colour;
        pending_duties.push_back(res);
    endtask

    task automatic compare_field(input string label, input logic [23:0] want,
                                 input logic [23:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
        end
    endtask

    // Receiver: checks each result, stalls by mode or on a hold-off request
    always @(posedge i_clk) begin
        t_duty_result want, got;
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            got = m_axis_tdata;
            if (pending_duties.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
                want = pending_duties.pop_front();
                compare_field("red_duty", 24'(want.red), 24'(got.red));
                compare_field("green_duty", 24'(want.green), 24'(got.green));
                compare_field("blue_duty", 24'(want.blue), 24'(got.blue));
                compare_field("current_colour", want.colour, got.colour);
            end
        end
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 99) < 65);
                default: begin
                    ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
                    m_axis_tready <= ready_pattern[15];
                end
            endcase
        end
    end

    // Offer one item and hold it until accepted
    task automatic send_item(input hrd_pkg::t_cmd cmd, input logic [23:0] rgb,
                             input logic [9:0] hue, input logic [7:0] sat,
                             input logic [7:0] val);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {6'd0, val, sat, hue, rgb};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        apply_led_command(cmd, rgb, hue, sat, val);
    endtask

    // Bursts of random length with random gaps between them
    task automatic pace_sender();
        if (!gaps_on) return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    endtask

    // Stop offering and let every expected result arrive
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_duties.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write; call only while the block is idle
    task automatic write_reg(input logic [0:0] addr, input logic [7:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == hrd_pkg::REG_BRIGHTNESS) brightness_q = data;
        else anode_q = data[0];
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_level();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return 8'h00;
        if (sel == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_item();
        hrd_pkg::t_cmd cmd;
        int            sel;
        logic [9:0]    hue;
        sel = $urandom_range(0, 99);
        if (sel < 40) cmd = hrd_pkg::CMD_SET_HSV;
        else if (sel < 75) cmd = hrd_pkg::CMD_SET_RGB;
        else if (sel < 95) cmd = hrd_pkg::CMD_REFRESH;
        else cmd = hrd_pkg::CMD_SPARE;
        if ($urandom_range(0, 3) == 0) hue = 10'($urandom());
        else hue = 10'($urandom_range(0, 359));
        send_item(cmd, 24'($urandom()), hue, pick_level(), pick_level());
    endtask

    // Reset state: colour is zero, full brightness, common cathode
    task automatic test_power_on();
        send_item(hrd_pkg::CMD_REFRESH, 24'hFFFFFF, 10'h1FF, 8'hFF, 8'hFF);
        send_item(hrd_pkg::CMD_SPARE, 24'hFFFFFF, 10'h1FF, 8'hFF, 8'hFF);
        wait_idle();
    endtask

    task automatic test_rgb_load();
        send_item(hrd_pkg::CMD_SET_RGB, 24'hFFFFFF, 10'h000, 8'h00, 8'h00);
        send_item(hrd_pkg::CMD_SET_RGB, 24'h000000, 10'h3FF, 8'hFF, 8'hFF);
        send_item(hrd_pkg::CMD_SET_RGB, 24'hA5A5A5, 10'h155, 8'h55, 8'hAA);
        send_item(hrd_pkg::CMD_SET_RGB, 24'h5A5A5A, 10'h2AA, 8'hAA, 8'h55);
        wait_idle();
    endtask

    // Every sector boundary, clamping on both sides, zero sat and zero value
    task automatic test_hsv_corners();
        send_item(hrd_pkg::CMD_SET_HSV, 24'h123456, 10'd0,   8'd255, 8'd255);
        send_item(hrd_pkg::CMD_SET_HSV, 24'h123456, 10'd59,  8'd255, 8'd255);
        send_item(hrd_pkg::CMD_SET_HSV, 24'h123456, 10'd60,  8'd255, 8'd255);
        send_item(hrd_pkg::CMD_SET_HSV, 24'h123456, 10'd119, 8'd200, 8'd255);
        send_item(hrd_pkg::CMD_SET_HSV, 24'h123456, 10'd120, 8'd255, 8'd128);
        send_item(hrd_pkg::CMD_SET_HSV, 24'h123456, 10'd180, 8'd128, 8'd200);
        send_item(hrd_pkg::CMD_SET_HSV, 24'h123456, 10'd240, 8'd255, 8'd255);
        send_item(hrd_pkg::CMD_SET_HSV, 24'h123456, 10'd300, 8'd255, 8'd255);
        send_item(hrd_pkg::CMD_SET_HSV, 24'h123456, 10'd359, 8'd255, 8'd255);
        // -512 and -1
        send_item(hrd_pkg::CMD_SET_HSV, 24'h123456, 10'h200, 8'd255, 8'd255);
        send_item(hrd_pkg::CMD_SET_HSV, 24'h123456, 10'h3FF, 8'd100, 8'd200);
        send_item(hrd_pkg::CMD_SET_HSV, 24'h123456, 10'd360, 8'd255, 8'd200);
        send_item(hrd_pkg::CMD_SET_HSV, 24'h123456, 10'd511, 8'd255, 8'd255);
        send_item(hrd_pkg::CMD_SET_HSV, 24'h123456, 10'd200, 8'd0,   8'd255);
        send_item(hrd_pkg::CMD_SET_HSV, 24'h123456, 10'd30,  8'd255, 8'd0);
        wait_idle();
    endtask

    // Brightness extremes, inversion, and only bit 0 kept for common_anode
    task automatic test_register_sweep();
        send_item(hrd_pkg::CMD_SET_RGB, 24'hFF8001, 10'd0, 8'd0, 8'd0);
        wait_idle();
        write_reg(hrd_pkg::REG_BRIGHTNESS, 8'd0);
        send_item(hrd_pkg::CMD_REFRESH, 24'd0, 10'd0, 8'd0, 8'd0);
        wait_idle();
        write_reg(hrd_pkg::REG_BRIGHTNESS, 8'd1);
        write_reg(hrd_pkg::REG_COMMON_ANODE, 8'h03);
        send_item(hrd_pkg::CMD_REFRESH, 24'd0, 10'd0, 8'd0, 8'd0);
        wait_idle();
        write_reg(hrd_pkg::REG_BRIGHTNESS, 8'd128);
        send_item(hrd_pkg::CMD_REFRESH, 24'd0, 10'd0, 8'd0, 8'd0);
        wait_idle();
        write_reg(hrd_pkg::REG_COMMON_ANODE, 8'hFE);
        write_reg(hrd_pkg::REG_BRIGHTNESS, 8'd255);
        send_item(hrd_pkg::CMD_REFRESH, 24'd0, 10'd0, 8'd0, 8'd0);
        wait_idle();
    endtask

    // Random traffic in phases, each with its own settings and flow control
    task automatic test_random_traffic();
        logic [7:0] bright_set[6] = '{8'd255, 8'd0, 8'd1, 8'd128, 8'd255, 8'd77};
        logic [7:0] anode_set[6]  = '{8'd0, 8'd1, 8'd0, 8'd1, 8'd1, 8'd0};
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) begin
                bright_set[ph] = 8'($urandom_range(0, 255));
                anode_set[ph] = 8'($urandom_range(0, 255));
            end
            write_reg(hrd_pkg::REG_BRIGHTNESS, bright_set[ph]);
            write_reg(hrd_pkg::REG_COMMON_ANODE, anode_set[ph]);
            stall_mode = ph % 3;
            ready_pattern = 16'($urandom_range(1, 16'hFFFF)) | 16'h0101;
            gaps_on = (ph != 0);
            burst_left = 0;
            for (int n = 0; n < 105; n++) begin
                send_random_item();
                pace_sender();
            end
            wait_idle();
        end
        stall_mode = 0;
        gaps_on = 1'b0;
    endtask

    // Receiver holds off for a long stretch while items keep coming
    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        stall_mode = 0;
        hold_req = 600;
        for (int n = 0; n < 20; n++) begin
            send_random_item();
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= hrd_pkg::CMD_SET_RGB;
        m_axis_tready <= 1'b0;
        brightness_q = 8'd255;
        anode_q = 1'b0;
        led_colour = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_power_on();
        test_rgb_load();
        test_hsv_corners();
        test_register_sweep();
        test_random_traffic();
        test_output_backpressure();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_duties.size() == 0) begin
            $display("hsv_rgb_led_dimmer_core_test: done, clean");
        end else begin
            $display("hsv_rgb_led_dimmer_core_test: done, errors");
        end
        $finish;
    end

endmodule
